// ----- rtl/core/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Command frame receiver package
// Header letters, parser codes, event kinds and the event record.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_N = 8'h4E;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_G = 8'h47;

  // First letter codes.
  localparam logic [2:0] LEAD_C = 3'd0;
  localparam logic [2:0] LEAD_D = 3'd1;
  localparam logic [2:0] LEAD_P = 3'd2;

  // Two letter codes.
  localparam logic [2:0] HDR_CX  = 3'd0;
  localparam logic [2:0] HDR_CN  = 3'd1;
  localparam logic [2:0] HDR_DC  = 3'd3;
  localparam logic [2:0] HDR_PN  = 3'd4;
  localparam logic [2:0] HDR_BAD = 3'd7;

  // Frame kinds, as reported on the event channel.
  localparam logic [2:0] KIND_CONNECT    = 3'd0;
  localparam logic [2:0] KIND_CONFIG     = 3'd1;
  localparam logic [2:0] KIND_CONTROL    = 3'd2;
  localparam logic [2:0] KIND_DISCONNECT = 3'd3;
  localparam logic [2:0] KIND_PING       = 3'd4;

  // Byte positions within a frame.
  localparam logic [2:0] POS_HDR0 = 3'd0;
  localparam logic [2:0] POS_HDR1 = 3'd1;
  localparam logic [2:0] POS_HDR2 = 3'd2;
  localparam logic [2:0] POS_BODY = 3'd3;

  // Position of the checksum byte for each frame length.
  localparam logic [2:0] SUM_POS_CONFIG  = 3'd7;
  localparam logic [2:0] SUM_POS_CONTROL = 3'd6;
  localparam logic [2:0] SUM_POS_SHORT   = 3'd4;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic        link_up;
    logic [7:0]  peer_address;
    logic [7:0]  speed_setpoint;
    logic [7:0]  stop_flag;
    logic [7:0]  accel_setpoint;
    logic [15:0] cable_dm;
    logic [19:0] position_limit;
  } event_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfr_rx_if.sv -----
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel that carries one received byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cfr_evt_if.sv -----
// ----------------------------------------------------------------------------
// Frame event channel
// Valid/ready channel that carries one event per accepted frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic        link_up;
  logic [7:0]  peer_address;
  logic [7:0]  speed_setpoint;
  logic [7:0]  stop_flag;
  logic [7:0]  accel_setpoint;
  logic [15:0] cable_dm;
  logic [19:0] position_limit;

  modport source (
    output valid, output event_kind, output link_up, output peer_address,
    output speed_setpoint, output stop_flag, output accel_setpoint,
    output cable_dm, output position_limit, input ready
  );
  modport sink (
    input valid, input event_kind, input link_up, input peer_address,
    input speed_setpoint, input stop_flag, input accel_setpoint,
    input cable_dm, input position_limit, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/command_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// Command frame receiver
// Parses the command byte stream and reports each accepted frame.
// ----------------------------------------------------------------------------
// Received bytes enter on rx_i, one byte per item. The receiver recognises the
// connect, configuration, control, disconnect and ping frames, checks their
// additive checksum and, once connected, the controller address. Each
// accepted frame produces one item on evt_o that carries the frame kind, the
// link state and the current setpoints, including the position limit.
// A byte is first captured in an input register and is parsed from there once
// the output register can advance, when the event is written to the output
// register. An event is thus registered when its checksum byte is parsed, and one
// byte is taken in every cycle while evt_o drains. If evt_o stalls while an event
// waits, the parser holds its byte; rx_i stays ready only while the input
// register is empty, so at most one more byte is taken before ready falls.
// Reset clears the link, the stored address, the setpoints and the parser,
// which then awaits the first header letter.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_receiver_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfr_rx_if.sink      rx_i,
  cfr_evt_if.source   evt_o
);
  import cfr_pkg::*;

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       out_vld_q;
  logic       out_vld_d;
  event_t     evt_q;
  event_t     evt_d;
  logic       advance;
  logic       consume;
  logic       emit;

  logic        link_q, link_d;
  logic [7:0]  peer_q, peer_d;
  logic [2:0]  idx_q, idx_d;
  logic [2:0]  ftype_q, ftype_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  pay_q [4];
  logic        pay_we;
  logic [1:0]  pay_sel;
  logic [7:0]  speed_q, speed_d;
  logic [7:0]  stop_q, stop_d;
  logic [7:0]  accel_q, accel_d;
  logic [15:0] cable_q, cable_d;
  logic [2:0]  sum_pos;
  logic [7:0]  sum_next;

  assign advance  = !out_vld_q || evt_o.ready;
  assign consume  = in_vld_q && advance;
  assign rx_i.ready = !in_vld_q || advance;
  assign sum_next = sum_q + byte_q;
  assign pay_sel  = idx_q[1:0] + 2'd1;

  always_comb begin
    if (ftype_q == KIND_CONFIG) begin
      sum_pos = SUM_POS_CONFIG;
    end else if (ftype_q == KIND_CONTROL) begin
      sum_pos = SUM_POS_CONTROL;
    end else begin
      sum_pos = SUM_POS_SHORT;
    end
  end

  always_comb begin
    link_d  = link_q;
    peer_d  = peer_q;
    idx_d   = idx_q;
    ftype_d = ftype_q;
    sum_d   = sum_q;
    speed_d = speed_q;
    stop_d  = stop_q;
    accel_d = accel_q;
    cable_d = cable_q;
    pay_we  = 1'b0;
    emit    = 1'b0;
    if (consume) begin
      unique case (idx_q)
        POS_HDR0: begin
          if (byte_q == CHAR_C) begin
            ftype_d = LEAD_C;
            sum_d   = byte_q;
            idx_d   = POS_HDR1;
          end else if (link_q && byte_q == CHAR_D) begin
            ftype_d = LEAD_D;
            sum_d   = byte_q;
            idx_d   = POS_HDR1;
          end else if (link_q && byte_q == CHAR_P) begin
            ftype_d = LEAD_P;
            sum_d   = byte_q;
            idx_d   = POS_HDR1;
          end
        end
        POS_HDR1: begin
          if (!link_q) begin
            if (byte_q != CHAR_X) begin
              idx_d = POS_HDR0;
            end else begin
              ftype_d = HDR_CX;
              sum_d   = sum_next;
              idx_d   = POS_HDR2;
            end
          end else if (byte_q != CHAR_N && byte_q != CHAR_C) begin
            idx_d = POS_HDR0;
          end else begin
            if (ftype_q == LEAD_C && byte_q == CHAR_N) begin
              ftype_d = HDR_CN;
            end else if (ftype_q == LEAD_D && byte_q == CHAR_C) begin
              ftype_d = HDR_DC;
            end else if (ftype_q == LEAD_P && byte_q == CHAR_N) begin
              ftype_d = HDR_PN;
            end else begin
              ftype_d = HDR_BAD;
            end
            sum_d = sum_next;
            idx_d = POS_HDR2;
          end
        end
        POS_HDR2: begin
          sum_d = sum_next;
          idx_d = POS_BODY;
          if (ftype_q == HDR_CX && byte_q == CHAR_N) begin
            ftype_d = KIND_CONNECT;
          end else if (ftype_q == HDR_CN && byte_q == CHAR_F) begin
            ftype_d = KIND_CONFIG;
          end else if (ftype_q == HDR_CN && byte_q == CHAR_T) begin
            ftype_d = KIND_CONTROL;
          end else if (ftype_q == HDR_DC && byte_q == CHAR_X) begin
            ftype_d = KIND_DISCONNECT;
          end else if (ftype_q == HDR_PN && byte_q == CHAR_G) begin
            ftype_d = KIND_PING;
          end else begin
            ftype_d = LEAD_C;
            sum_d   = sum_q;
            idx_d   = POS_HDR0;
          end
        end
        default: begin
          if (idx_q < sum_pos) begin
            pay_we = 1'b1;
            sum_d  = sum_next;
            idx_d  = idx_q + 3'd1;
          end else begin
            idx_d = POS_HDR0;
            if (byte_q == sum_q) begin
              if (ftype_q == KIND_CONNECT) begin
                link_d = 1'b1;
                peer_d = pay_q[0];
                emit   = 1'b1;
              end else if (pay_q[0] == peer_q) begin
                emit = 1'b1;
                if (ftype_q == KIND_CONFIG) begin
                  accel_d = pay_q[1];
                  cable_d = {pay_q[2], pay_q[3]};
                end else if (ftype_q == KIND_CONTROL) begin
                  speed_d = pay_q[1];
                  stop_d  = pay_q[2];
                end else if (ftype_q == KIND_DISCONNECT) begin
                  link_d = 1'b0;
                  peer_d = '0;
                end else if (ftype_q != KIND_PING) begin
                  emit = 1'b0;
                end
              end
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    evt_d.event_kind     = ftype_q;
    evt_d.link_up        = link_d;
    evt_d.peer_address   = peer_d;
    evt_d.speed_setpoint = speed_d;
    evt_d.stop_flag      = stop_d;
    evt_d.accel_setpoint = accel_d;
    evt_d.cable_dm       = cable_d;
    evt_d.position_limit = ({4'd0, cable_d} << 3) + ({4'd0, cable_d} << 1);
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      link_q    <= 1'b0;
      peer_q    <= '0;
      idx_q     <= POS_HDR0;
      ftype_q   <= LEAD_C;
      sum_q     <= '0;
      speed_q   <= '0;
      stop_q    <= '0;
      accel_q   <= '0;
      cable_q   <= '0;
    end else begin
      if (rx_i.ready) begin
        in_vld_q <= rx_i.valid;
      end
      out_vld_q <= out_vld_d;
      link_q    <= link_d;
      peer_q    <= peer_d;
      idx_q     <= idx_d;
      ftype_q   <= ftype_d;
      sum_q     <= sum_d;
      speed_q   <= speed_d;
      stop_q    <= stop_d;
      accel_q   <= accel_d;
      cable_q   <= cable_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      byte_q <= rx_i.rx_byte;
    end
    if (pay_we) begin
      pay_q[pay_sel] <= byte_q;
    end
    if (advance && emit) begin
      evt_q <= evt_d;
    end
  end

  assign evt_o.valid          = out_vld_q;
  assign evt_o.event_kind     = evt_q.event_kind;
  assign evt_o.link_up        = evt_q.link_up;
  assign evt_o.peer_address   = evt_q.peer_address;
  assign evt_o.speed_setpoint = evt_q.speed_setpoint;
  assign evt_o.stop_flag      = evt_q.stop_flag;
  assign evt_o.accel_setpoint = evt_q.accel_setpoint;
  assign evt_o.cable_dm       = evt_q.cable_dm;
  assign evt_o.position_limit = evt_q.position_limit;

  a_addr_cleared_when_down: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !link_q |-> peer_q == '0
  ) else $error("Stored address is not cleared while the link is down.");

  a_body_has_kind: assert property (
    @(posedge clk_i) disable iff (!rst_ni) idx_q >= POS_BODY |-> ftype_q <= KIND_PING
  ) else $error("Frame body is parsed without a valid frame kind.");

  a_event_needs_byte: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !$past(out_vld_q) |-> $past(in_vld_q)
  ) else $error("An event appeared without a parsed byte.");

  a_link_matches_kind: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (evt_q.event_kind == KIND_CONNECT
                  || evt_q.event_kind == KIND_DISCONNECT)
    |-> evt_q.link_up == (evt_q.event_kind == KIND_CONNECT)
  ) else $error("Link state in the event disagrees with the frame kind.");

endmodule

`default_nettype wire
